>>> hdl/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// shared types and constants for the button debounce and repeat unit
// ----------------------------------------------------------------------------
package bdr_pkg;

   // button slots as indexed on the per-button lines
   localparam int NUM_LINES = 3;
   localparam int BTN_OK    = 0;
   localparam int BTN_DOWN  = 1;
   localparam int BTN_UP    = 2;

   // parameter defaults
   localparam int NUM_BUTTONS_DEFAULT = 3;
   localparam int COUNT_BITS_DEFAULT  = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int TICK_BITS      = 16;
   localparam int ENABLE_BITS    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS     = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_TICKS   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_ENABLE  = CSR_INDEX_BITS'(3);

   // reset values, sized for a 10 ms tick
   localparam logic [TICK_BITS-1:0]   DEBOUNCE_TICKS_RESET = TICK_BITS'(8);
   localparam logic [TICK_BITS-1:0]   HOLD_TICKS_RESET     = TICK_BITS'(50);
   localparam logic [TICK_BITS-1:0]   REPEAT_TICKS_RESET   = TICK_BITS'(10);
   localparam logic [ENABLE_BITS-1:0] REPEAT_ENABLE_RESET  = ENABLE_BITS'(0);

   typedef struct packed {
      logic ok_level;
      logic down_level;
      logic up_level;
   } bdr_req_type;

   typedef struct packed {
      logic ok_pressed;
      logic down_pressed;
      logic up_pressed;
      logic ok_held;
      logic down_held;
      logic up_held;
   } bdr_rsp_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]   debounce_ticks;
      logic [TICK_BITS-1:0]   hold_ticks;
      logic [TICK_BITS-1:0]   repeat_ticks;
      logic [ENABLE_BITS-1:0] repeat_enable;
   } bdr_cfg_type;

endpackage

>>> hdl/button_debounce_repeat_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_repeat_unit
// debounce and auto-repeat for the ok, down and up buttons
// ----------------------------------------------------------------------------
// usage
//   req_*  : one request per tick, raw active-low levels of ok, down and up
//   rsp_*  : one response per request, pressed and held flags after the tick
//   csr_*  : register writes (0 debounce, 1 hold, 2 repeat ticks, 3 enables),
//            always ready, unchecked: write only while no request is in flight
// latency and throughput
//   the response is valid the cycle after its request is taken; one request
//   per cycle unless stalled, set by the single flag/counter update per button
// reset
//   counters and flags clear, registers load 8 / 50 / 10 ticks, repeat off;
//   a press on the first tick after reset is accepted at once
// stall
//   the flag registers double as the response register, so while a response
//   waits with rsp_ready low, req_ready stays low; the request is taken in the
//   same cycle the waiting response leaves
// ----------------------------------------------------------------------------
module button_debounce_repeat_unit
   import bdr_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT,
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // tick requests
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bdr_req_type               req_data,
   // responses
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bdr_rsp_type               rsp_data,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   bdr_cfg_type            cfg;
   logic                   req_take;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [NUM_BUTTONS-1:0] released;
   logic [NUM_BUTTONS-1:0] may_repeat;
   logic [NUM_BUTTONS-1:0] pressed;
   logic [NUM_BUTTONS-1:0] held;
   logic [NUM_LINES-1:0]   pressed_line;
   logic [NUM_LINES-1:0]   held_line;

   // register file, writes never stall
   assign csr_ready = 1'b1;

   bdr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // take a request when no response waits or the waiting one leaves now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // per-button level and repeat enable; extra buttons read as released
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
      if (b == BTN_OK) begin : g_ok
         assign released[b]   = req_data.ok_level;
         assign may_repeat[b] = 1'b0;              // ok never repeats
      end else if (b == BTN_DOWN) begin : g_down
         assign released[b]   = req_data.down_level;
         assign may_repeat[b] = cfg.repeat_enable[0];
      end else if (b == BTN_UP) begin : g_up
         assign released[b]   = req_data.up_level;
         assign may_repeat[b] = cfg.repeat_enable[1];
      end else begin : g_extra
         assign released[b]   = 1'b1;
         assign may_repeat[b] = 1'b0;
      end

      bdr_button #(
         .COUNT_BITS (COUNT_BITS)
      ) u_button (
         .clock      (clock),
         .reset      (reset),
         .step       (req_take),
         .released   (released[b]),
         .may_repeat (may_repeat[b]),
         .cfg        (cfg),
         .pressed    (pressed[b]),
         .held       (held[b])
      );
   end

   // map buttons onto response lines, missing buttons read as zero
   for (genvar l = 0; l < NUM_LINES; l++) begin : g_line
      if (l < NUM_BUTTONS) begin : g_have
         assign pressed_line[l] = pressed[l];
         assign held_line[l]    = held[l];
      end else begin : g_none
         assign pressed_line[l] = 1'b0;
         assign held_line[l]    = 1'b0;
      end
   end

   // response valid tracks the flag registers
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.ok_pressed   = pressed_line[BTN_OK];
   assign rsp_data.down_pressed = pressed_line[BTN_DOWN];
   assign rsp_data.up_pressed   = pressed_line[BTN_UP];
   assign rsp_data.ok_held      = held_line[BTN_OK];
   assign rsp_data.down_held    = held_line[BTN_DOWN];
   assign rsp_data.up_held      = held_line[BTN_UP];

   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("taken request produced no response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while a response is stalled");

   a_response_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take))
      else $error("response appeared without a request");

endmodule

>>> hdl/bdr_csr.sv
// ----------------------------------------------------------------------------
// bdr_csr
// configuration registers: tick lengths and repeat enables
// ----------------------------------------------------------------------------
module bdr_csr
   import bdr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output bdr_cfg_type               cfg
);

   bdr_cfg_type cfg_ff;
   bdr_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = TICK_BITS'(wr_data);
            CSR_HOLD_TICKS:     cfg_in.hold_ticks     = TICK_BITS'(wr_data);
            CSR_REPEAT_TICKS:   cfg_in.repeat_ticks   = TICK_BITS'(wr_data);
            CSR_REPEAT_ENABLE:  cfg_in.repeat_enable  = wr_data[ENABLE_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_TICKS_RESET;
         cfg_ff.hold_ticks     <= HOLD_TICKS_RESET;
         cfg_ff.repeat_ticks   <= REPEAT_TICKS_RESET;
         cfg_ff.repeat_enable  <= REPEAT_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/bdr_button.sv
// ----------------------------------------------------------------------------
// bdr_button
// one button: tick counter with held and pressed flags
// ----------------------------------------------------------------------------
module bdr_button
   import bdr_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        released,
   input  logic        may_repeat,
   input  bdr_cfg_type cfg,
   output logic        pressed,
   output logic        held
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  held_ff;
   logic                  held_in;
   logic                  pressed_ff;
   logic                  pressed_in;

   always_comb begin
      count_in   = count_ff;
      held_in    = held_ff;
      pressed_in = pressed_ff;
      if (step) begin
         if (released) begin
            held_in    = 1'b0;
            pressed_in = 1'b0;
            count_in   = COUNT_BITS'(cfg.debounce_ticks);
         end else if (count_ff != '0) begin
            // still debouncing or waiting out hold / repeat delay
            pressed_in = 1'b0;
            count_in   = count_ff - COUNT_BITS'(1);
         end else if (!held_ff) begin
            // first accept of this press
            held_in    = 1'b1;
            pressed_in = 1'b1;
            count_in   = COUNT_BITS'(cfg.hold_ticks);
         end else if (may_repeat) begin
            pressed_in = 1'b1;
            count_in   = COUNT_BITS'(cfg.repeat_ticks);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         held_ff    <= 1'b0;
         pressed_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         held_ff    <= held_in;
         pressed_ff <= pressed_in;
      end
   end

   assign pressed = pressed_ff;
   assign held    = held_ff;

   a_pressed_needs_held: assert property (@(posedge clock) disable iff (reset)
      pressed_ff |-> held_ff)
      else $error("pressed flag set on a button that is not held");

   a_held_drops_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(held_ff) |-> ($past(step && released) || $past(reset)))
      else $error("held flag cleared without a released level");

endmodule

>>> tb/button_debounce_repeat_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_repeat_unit_test
// self-checking bench for the button debounce and repeat unit: a short walk
// through a table of ticks and register writes, then random press and bounce
// patterns under several register settings, each response checked against a
// cycle-free model of the per-button counter and flags, or typed-in flags
// ----------------------------------------------------------------------------
module button_debounce_repeat_unit_test;
   import bdr_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int MAX_GAP         = 14;
   localparam int STALL_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 8;
   localparam int RANDOM_PHASES   = 10;
   localparam int TICKS_PER_PHASE = 85;

   // index that maps to no register, writes to it must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = CSR_INDEX_BITS'(15);

   // level patterns, ok is the msb of the request
   localparam bdr_req_type ALL_PRESSED  = bdr_req_type'(3'b000);
   localparam bdr_req_type ALL_RELEASED = bdr_req_type'(3'b111);
   localparam bdr_req_type ONLY_DOWN    = bdr_req_type'(3'b101);
   localparam bdr_req_type ONLY_UP      = bdr_req_type'(3'b110);
   localparam bdr_req_type OK_AND_UP    = bdr_req_type'(3'b010);

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  wdata;
      bdr_req_type               levels;
      bit                        typed;
      bdr_rsp_type               flags;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_ready;
   bdr_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   bdr_rsp_type               rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // shadow of the block: registers, per-button counters and flags
   bdr_cfg_type                   shadow_cfg;
   logic [COUNT_BITS_DEFAULT-1:0] btn_count [NUM_LINES];
   logic [NUM_LINES-1:0]          btn_held;
   logic [NUM_LINES-1:0]          btn_pressed;

   // flags still owed by the block, oldest first
   bdr_rsp_type  flags_due [$];
   plan_row_type tick_plan [$];

   int errors = 0;
   int stall_cycles = 0;
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   button_debounce_repeat_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // model of one tick: each button either reloads, counts down, accepts,
   // repeats or keeps its flags
   // ---------------------------------------------------------------------
   function automatic bdr_rsp_type debounce_step(input bdr_req_type levels);
      logic [NUM_LINES-1:0] released;
      bdr_rsp_type          flags;
      released[BTN_OK]   = levels.ok_level;
      released[BTN_DOWN] = levels.down_level;
      released[BTN_UP]   = levels.up_level;
      for (int b = 0; b < NUM_LINES; b++) begin
         if (released[b]) begin
            btn_held[b]    = 1'b0;
            btn_pressed[b] = 1'b0;
            btn_count[b]   = shadow_cfg.debounce_ticks;
         end else if (btn_count[b] != '0) begin
            // still settling, or waiting out hold / repeat time
            btn_pressed[b] = 1'b0;
            btn_count[b]   = btn_count[b] - 1'b1;
         end else if (!btn_held[b]) begin
            // first accept of this press
            btn_held[b]    = 1'b1;
            btn_pressed[b] = 1'b1;
            btn_count[b]   = shadow_cfg.hold_ticks;
         end else if ((b == BTN_DOWN && shadow_cfg.repeat_enable[0]) ||
                      (b == BTN_UP && shadow_cfg.repeat_enable[1])) begin
            btn_pressed[b] = 1'b1;
            btn_count[b]   = shadow_cfg.repeat_ticks;
         end
         // held with repeat off: pressed keeps whatever it had
      end
      flags.ok_pressed   = btn_pressed[BTN_OK];
      flags.down_pressed = btn_pressed[BTN_DOWN];
      flags.up_pressed   = btn_pressed[BTN_UP];
      flags.ok_held      = btn_held[BTN_OK];
      flags.down_held    = btn_held[BTN_DOWN];
      flags.up_held      = btn_held[BTN_UP];
      return flags;
   endfunction

   function automatic int next_send_gap();
      if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
      return send_burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // register values: mostly short, now and then the extremes or anything
   function automatic logic [TICK_BITS-1:0] pick_ticks(input int short_max);
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return TICK_BITS'($urandom_range(0, 65535));
         default: return TICK_BITS'($urandom_range(0, short_max));
      endcase
   endfunction

   function automatic void add_tick(input bdr_req_type levels, input bit typed,
                                    input bdr_rsp_type flags);
      plan_row_type row;
      row = '{kind: ROW_TICK, index: '0, wdata: '0, levels: levels,
              typed: typed, flags: flags};
      tick_plan.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_INDEX_BITS-1:0] index,
                                     input logic [CSR_DATA_BITS-1:0] wdata);
      plan_row_type row;
      row = '{kind: ROW_WRITE, index: index, wdata: wdata, levels: ALL_RELEASED,
              typed: 1'b0, flags: '0};
      tick_plan.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // request side, entered and left at a falling edge; valid stays up after
   // the request is taken so the next one can follow with no gap
   // ---------------------------------------------------------------------
   task automatic send_tick(input bdr_req_type levels, input int gap, input bit typed,
                            input bdr_rsp_type flags);
      bdr_rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = debounce_step(levels);
      flags_due.push_back(typed ? flags : predicted);
      @(negedge clock);
   endtask

   // drop valid and hold off until every response is back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(negedge clock);
      while (flags_due.size() != 0) @(negedge clock);
   endtask

   // csr valid is left high for back-to-back writes, the caller lowers it
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_DEBOUNCE_TICKS: shadow_cfg.debounce_ticks = wdata[TICK_BITS-1:0];
         CSR_HOLD_TICKS:     shadow_cfg.hold_ticks     = wdata[TICK_BITS-1:0];
         CSR_REPEAT_TICKS:   shadow_cfg.repeat_ticks   = wdata[TICK_BITS-1:0];
         CSR_REPEAT_ENABLE:  shadow_cfg.repeat_enable  = wdata[ENABLE_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic check_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // response side: random back-pressure with bursts of always-ready
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) take_burst = ~take_burst;
         gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // every taken response is matched against the oldest owed flags
   always @(posedge clock) begin
      bdr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flags_due.size() == 0) begin
            errors++;
            $display("%0t: response with none owed, actual %b", $time, rsp_data);
         end else begin
            want = flags_due.pop_front();
            check_flag("ok_pressed", want.ok_pressed, rsp_data.ok_pressed);
            check_flag("down_pressed", want.down_pressed, rsp_data.down_pressed);
            check_flag("up_pressed", want.up_pressed, rsp_data.up_pressed);
            check_flag("ok_held", want.ok_held, rsp_data.ok_held);
            check_flag("down_held", want.down_held, rsp_data.down_held);
            check_flag("up_held", want.up_held, rsp_data.up_held);
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [NUM_LINES-1:0] level;
      logic [NUM_LINES-1:0] bounce;
      int                   run_left [NUM_LINES];
      bit                   writing;
      bdr_req_type          levels;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = ALL_RELEASED;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      shadow_cfg = '{debounce_ticks: DEBOUNCE_TICKS_RESET, hold_ticks: HOLD_TICKS_RESET,
                     repeat_ticks: REPEAT_TICKS_RESET, repeat_enable: REPEAT_ENABLE_RESET};
      for (int b = 0; b < NUM_LINES; b++) btn_count[b] = '0;
      btn_held    = '0;
      btn_pressed = '0;

      // directed table; flags are typed in where they are obvious
      // counters start at zero, so a press on the first tick is taken at once
      add_tick(ALL_PRESSED, 1'b1, bdr_rsp_type'(6'b111111));
      // hold time of 50 running: pulse ends, held stays
      add_tick(ALL_PRESSED, 1'b1, bdr_rsp_type'(6'b000111));
      add_tick(ALL_RELEASED, 1'b1, bdr_rsp_type'(6'b000000));
      add_tick(ALL_PRESSED, 1'b0, '0);
      // zero debounce / hold / repeat, enable written with extra high bits
      add_write(CSR_DEBOUNCE_TICKS, '0);
      add_write(CSR_HOLD_TICKS, '0);
      add_write(CSR_REPEAT_TICKS, '0);
      add_write(CSR_REPEAT_ENABLE, '1);
      add_write(CSR_UNMAPPED, '1);
      add_tick(ALL_RELEASED, 1'b1, bdr_rsp_type'(6'b000000));
      add_tick(ALL_PRESSED, 1'b0, '0);
      add_tick(ALL_PRESSED, 1'b0, '0);
      // held with repeat off, pressed keeps its last value
      add_write(CSR_REPEAT_ENABLE, '0);
      add_tick(ALL_PRESSED, 1'b0, '0);
      add_tick(OK_AND_UP, 1'b0, '0);
      // longest times
      add_write(CSR_DEBOUNCE_TICKS, '1);
      add_write(CSR_HOLD_TICKS, '1);
      add_write(CSR_REPEAT_TICKS, '1);
      add_tick(ALL_RELEASED, 1'b1, bdr_rsp_type'(6'b000000));
      add_tick(ALL_PRESSED, 1'b1, bdr_rsp_type'(6'b000000));
      add_tick(ONLY_DOWN, 1'b0, '0);
      // short times, repeat on down only, then on up only
      add_write(CSR_DEBOUNCE_TICKS, CSR_DATA_BITS'(1));
      add_write(CSR_HOLD_TICKS, CSR_DATA_BITS'(2));
      add_write(CSR_REPEAT_TICKS, CSR_DATA_BITS'(1));
      add_write(CSR_REPEAT_ENABLE, CSR_DATA_BITS'(1));
      add_tick(ALL_RELEASED, 1'b0, '0);
      repeat (7) add_tick(ONLY_DOWN, 1'b0, '0);
      add_write(CSR_REPEAT_ENABLE, CSR_DATA_BITS'(2));
      repeat (4) add_tick(ONLY_UP, 1'b0, '0);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      writing = 1'b0;
      foreach (tick_plan[i]) begin
         if (tick_plan[i].kind == ROW_WRITE) begin
            // registers only change with nothing in flight
            if (!writing) wait_quiet();
            writing = 1'b1;
            write_reg(tick_plan[i].index, tick_plan[i].wdata);
         end else begin
            if (writing) csr_valid <= 1'b0;
            writing = 1'b0;
            send_tick(tick_plan[i].levels, next_send_gap(), tick_plan[i].typed,
                      tick_plan[i].flags);
         end
      end

      // random phases: new settings, then press runs with some bounce
      level = '1;
      for (int b = 0; b < NUM_LINES; b++) run_left[b] = $urandom_range(0, 5);
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_quiet();
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_UNMAPPED, CSR_DATA_BITS'($urandom_range(0, 65535)));
         write_reg(CSR_DEBOUNCE_TICKS, pick_ticks(6));
         write_reg(CSR_HOLD_TICKS, pick_ticks(10));
         write_reg(CSR_REPEAT_TICKS, pick_ticks(4));
         write_reg(CSR_REPEAT_ENABLE, CSR_DATA_BITS'($urandom_range(0, 65535)));
         csr_valid <= 1'b0;
         @(negedge clock);

         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            for (int b = 0; b < NUM_LINES; b++) begin
               if (run_left[b] == 0) begin
                  level[b]    = ~level[b];
                  run_left[b] = level[b] ? $urandom_range(1, 12) : $urandom_range(1, 40);
               end
               run_left[b]--;
               bounce[b] = ($urandom_range(0, 19) == 0);
            end
            levels.ok_level   = level[BTN_OK] ^ bounce[BTN_OK];
            levels.down_level = level[BTN_DOWN] ^ bounce[BTN_DOWN];
            levels.up_level   = level[BTN_UP] ^ bounce[BTN_UP];
            // now and then let everything drain mid-phase
            if ($urandom_range(0, 59) == 0) wait_quiet();
            send_tick(levels, next_send_gap(), 1'b0, '0);
         end
      end

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (flags_due.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never came", $time, flags_due.size());
      end
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
